// ===== hw/rtl/ip_address_text_parser_top_macros.svh =====
// assertion macros for the ip address text parser
// expects clk and arst_n in the scope of use
`ifndef IP_ADDRESS_TEXT_PARSER_TOP_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_TOP_MACROS_SVH

`ifndef SYNTH
`define IPATP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same cycle implication");
`define IPATP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle implication");
`else
`define IPATP_ASSERT_IMPL(lbl, ante, cons)
`define IPATP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/ipatp_pkg.sv =====
// shared types and constants for the ip address text parser
// no dependencies
`timescale 1ns / 1ps

package ipatp_pkg;

	typedef logic [15:0] group_t;
	typedef logic [7:0]  octet_t;

	localparam int unsigned V6_GROUPS  = 8;
	localparam int unsigned V4_DOTS    = 3;
	localparam int unsigned MAX_DIGITS = 4;
	localparam int unsigned DOT_SAT    = 7;
	localparam int unsigned COLON_SAT  = 15;

	localparam logic [8:0]  DEC_SAT    = 9'd256;
	localparam logic [8:0]  OCTET_MAX  = 9'd255;

	localparam logic [7:0]  CH_DIG_LO  = 8'h30;
	localparam logic [7:0]  CH_DIG_HI  = 8'h39;
	localparam logic [7:0]  CH_UC_LO   = 8'h41;
	localparam logic [7:0]  CH_UC_HI   = 8'h46;
	localparam logic [7:0]  CH_LC_LO   = 8'h61;
	localparam logic [7:0]  CH_LC_HI   = 8'h66;
	localparam logic [7:0]  CH_DOT     = 8'h2e;
	localparam logic [7:0]  CH_COLON   = 8'h3a;

	localparam logic [15:0] V4_MAP_TAG = 16'hffff;

	localparam int unsigned DATA_W = 128;
	localparam int unsigned USER_W = 2;

endpackage

// ===== hw/rtl/ip_address_text_parser_top.sv =====
// Parses IPv4 dotted or IPv6 colon-hex address text, one ASCII character per
// input beat (tlast on the final character), and gives one 128-bit result beat
// per text. Each beat is registered, then combinational logic updates parse
// state, so a new character is taken every clock cycle; the input stalls only
// while a finished result beat is held in the output register by m_tready low
// and the next last character waits. The result beat enters the output register
// as its last character leaves the input stage. IPv4 comes out mapped as
// ::ffff:a.b.c.d; invalid text gives addr_valid = 0 and an all-zero address.
// Depends on ipatp_pkg and ip_address_text_parser_top_macros.svh.
`timescale 1ns / 1ps
`include "ip_address_text_parser_top_macros.svh"

module ip_address_text_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // text_byte
	input  logic                        s_tlast,  // is_last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ipatp_pkg::DATA_W-1:0] m_tdata, // addr_high, addr_low
	output logic [ipatp_pkg::USER_W-1:0] m_tuser  // addr_valid, was_ipv4
);
	import ipatp_pkg::*;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv;
	logic        out_free;

	// parse state
	group_t      hg_q [V6_GROUPS];
	logic [3:0]  gc_q;
	logic        gs_q;
	logic [3:0]  gp_q;
	group_t      cur_q;
	logic [2:0]  dc_q;
	octet_t      oct_q [V4_DOTS];
	logic [2:0]  dot_q;
	logic [3:0]  col_q;
	logic        prev_q;
	logic        v4b_q;
	logic        v6b_q;
	logic [8:0]  dec_q;
	logic        lone_q;
	logic        gcl_q;

	// next state
	group_t      n_hg [V6_GROUPS];
	logic [3:0]  n_gc;
	logic        n_gs;
	logic [3:0]  n_gp;
	group_t      n_cur;
	logic [2:0]  n_dc;
	octet_t      n_oct [V4_DOTS];
	logic [2:0]  n_dot;
	logic [3:0]  n_col;
	logic        n_prev;
	logic        n_v4b;
	logic        n_v6b;
	logic [8:0]  n_dec;
	logic        n_lone;
	logic        n_gcl;

	// classification
	logic        is_dig;
	logic        is_uc;
	logic        is_lc;
	logic [3:0]  nib;
	logic [12:0] dec_prod;

	// final evaluation
	group_t      f_hg [V6_GROUPS];
	logic [3:0]  f_gc;
	logic [3:0]  f_g;
	logic        f_v6b;
	logic        v4_ok;
	group_t      full [V6_GROUPS];
	logic [4:0]  tail_lo;
	logic [4:0]  jsum [V6_GROUPS];
	logic [63:0] res_hi;
	logic [63:0] res_lo;
	logic        res_valid;
	logic        res_v4;

	// output register
	logic                  out_valid_q;
	logic [DATA_W-1:0]     out_data_q;
	logic [USER_W-1:0]     out_user_q;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign is_dig   = (byte_s1 >= CH_DIG_LO) && (byte_s1 <= CH_DIG_HI);
	assign is_uc    = (byte_s1 >= CH_UC_LO) && (byte_s1 <= CH_UC_HI);
	assign is_lc    = (byte_s1 >= CH_LC_LO) && (byte_s1 <= CH_LC_HI);
	assign dec_prod = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0} + {9'd0, nib};

	always_comb begin
		priority if (is_dig) begin
			nib = 4'(byte_s1 - CH_DIG_LO);
		end else if (is_uc) begin
			nib = 4'(byte_s1 - CH_UC_LO + 8'd10);
		end else if (is_lc) begin
			nib = 4'(byte_s1 - CH_LC_LO + 8'd10);
		end else begin
			nib = 4'd0;
		end
	end

	always_comb begin
		n_hg   = hg_q;
		n_gc   = gc_q;
		n_gs   = gs_q;
		n_gp   = gp_q;
		n_cur  = cur_q;
		n_dc   = dc_q;
		n_oct  = oct_q;
		n_dot  = dot_q;
		n_col  = col_q;
		n_prev = prev_q;
		n_v4b  = v4b_q;
		n_v6b  = v6b_q;
		n_dec  = dec_q;
		n_lone = lone_q;
		n_gcl  = gcl_q;
		priority if (is_dig || is_uc || is_lc) begin
			if (is_dig) begin
				n_dec = (dec_prod > 13'(DEC_SAT)) ? DEC_SAT : dec_prod[8:0];
			end else begin
				n_v4b = 1'b1;
			end
			if (lone_q) n_v6b = 1'b1;
			if (dc_q >= 3'(MAX_DIGITS)) begin
				n_v6b = 1'b1;
			end else begin
				n_cur = {cur_q[11:0], nib};
				n_dc  = dc_q + 3'd1;
			end
			n_prev = 1'b0;
			n_gcl  = 1'b0;
		end else if (byte_s1 == CH_DOT) begin
			n_v6b = 1'b1;
			if (dot_q >= 3'(V4_DOTS) || dec_q > OCTET_MAX) begin
				n_v4b = 1'b1;
			end else begin
				n_oct[dot_q[1:0]] = dec_q[7:0];
			end
			if (dot_q < 3'(DOT_SAT)) n_dot = dot_q + 3'd1;
			n_dec  = 9'd0;
			n_prev = 1'b0;
			n_gcl  = 1'b0;
		end else if (byte_s1 == CH_COLON) begin
			n_v4b = 1'b1;
			if (col_q < 4'(COLON_SAT)) n_col = col_q + 4'd1;
			if (prev_q) begin
				if (gcl_q || gs_q) begin
					n_v6b = 1'b1;
				end else begin
					n_gs  = 1'b1;
					n_gp  = gc_q;
					n_gcl = 1'b1;
				end
				n_lone = 1'b0;
			end else begin
				if (dc_q != 3'd0) begin
					if (gc_q >= 4'(V6_GROUPS)) begin
						n_v6b = 1'b1;
					end else begin
						n_hg[gc_q[2:0]] = cur_q;
						n_gc            = gc_q + 4'd1;
					end
					n_cur = '0;
					n_dc  = 3'd0;
				end else begin
					n_lone = 1'b1;
				end
				n_gcl = 1'b0;
			end
			n_prev = 1'b1;
		end else begin
			n_v4b = 1'b1;
			n_v6b = 1'b1;
		end
	end

	// end-of-text evaluation on the updated state
	always_comb begin
		f_hg  = n_hg;
		f_gc  = n_gc;
		f_v6b = n_v6b;
		v4_ok = !n_v4b && (n_dot == 3'(V4_DOTS)) && (n_dec <= OCTET_MAX);
		if (n_lone || (n_prev && !n_gcl)) f_v6b = 1'b1;
		if (n_dc != 3'd0) begin
			if (n_gc >= 4'(V6_GROUPS)) begin
				f_v6b = 1'b1;
			end else begin
				f_hg[n_gc[2:0]] = n_cur;
				f_gc            = n_gc + 4'd1;
			end
		end
		if (n_col == 4'd0) f_v6b = 1'b1;
		if (n_gs ? (f_gc > 4'(V6_GROUPS - 1)) : (f_gc != 4'(V6_GROUPS))) f_v6b = 1'b1;
		f_g     = n_gs ? ((n_gp > f_gc) ? f_gc : n_gp) : f_gc;
		tail_lo = 5'(V6_GROUPS) - {1'b0, f_gc} + {1'b0, f_g};
		for (int j = 0; j < V6_GROUPS; j++) begin
			jsum[j] = 5'(j) + {1'b0, f_gc};
			if (4'(j) < f_g) begin
				full[j] = f_hg[j];
			end else if (5'(j) >= tail_lo) begin
				full[j] = f_hg[jsum[j][2:0]];
			end else begin
				full[j] = '0;
			end
		end
		if (v4_ok) begin
			res_valid = 1'b1;
			res_v4    = 1'b1;
			res_hi    = '0;
			res_lo    = {16'h0000, V4_MAP_TAG, n_oct[0], n_oct[1], n_oct[2], n_dec[7:0]};
		end else if (!f_v6b) begin
			res_valid = 1'b1;
			res_v4    = 1'b0;
			res_hi    = {full[0], full[1], full[2], full[3]};
			res_lo    = {full[4], full[5], full[6], full[7]};
		end else begin
			res_valid = 1'b0;
			res_v4    = 1'b0;
			res_hi    = '0;
			res_lo    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < V6_GROUPS; i++) hg_q[i] <= '0;
			for (int i = 0; i < V4_DOTS; i++) oct_q[i] <= '0;
			gc_q   <= '0;
			gs_q   <= 1'b0;
			gp_q   <= '0;
			cur_q  <= '0;
			dc_q   <= '0;
			dot_q  <= '0;
			col_q  <= '0;
			prev_q <= 1'b0;
			v4b_q  <= 1'b0;
			v6b_q  <= 1'b0;
			dec_q  <= '0;
			lone_q <= 1'b0;
			gcl_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				for (int i = 0; i < V6_GROUPS; i++) hg_q[i] <= '0;
				for (int i = 0; i < V4_DOTS; i++) oct_q[i] <= '0;
				gc_q   <= '0;
				gs_q   <= 1'b0;
				gp_q   <= '0;
				cur_q  <= '0;
				dc_q   <= '0;
				dot_q  <= '0;
				col_q  <= '0;
				prev_q <= 1'b0;
				v4b_q  <= 1'b0;
				v6b_q  <= 1'b0;
				dec_q  <= '0;
				lone_q <= 1'b0;
				gcl_q  <= 1'b0;
			end else begin
				hg_q   <= n_hg;
				oct_q  <= n_oct;
				gc_q   <= n_gc;
				gs_q   <= n_gs;
				gp_q   <= n_gp;
				cur_q  <= n_cur;
				dc_q   <= n_dc;
				dot_q  <= n_dot;
				col_q  <= n_col;
				prev_q <= n_prev;
				v4b_q  <= n_v4b;
				v6b_q  <= n_v6b;
				dec_q  <= n_dec;
				lone_q <= n_lone;
				gcl_q  <= n_gcl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_data_q <= {res_lo, res_hi};
			out_user_q <= {res_v4, res_valid};
		end
	end

	// input stalls only when a finished result beat is blocked
	`IPATP_ASSERT_IMPL(a_stall_cause, !s_tready, valid_s1 && last_s1 && out_valid_q && !m_tready)
	// an ipv4 result is always valid and mapped
	`IPATP_ASSERT_IMPL(a_v4_mapped, out_valid_q && out_user_q[1], out_user_q[0] && out_data_q[63:0] == 64'd0 && out_data_q[127:96] == {16'h0000, V4_MAP_TAG})
	// an invalid result carries a zero address
	`IPATP_ASSERT_IMPL(a_bad_zero, out_valid_q && !out_user_q[0], out_data_q == '0 && !out_user_q[1])
	// parse state is cleared after the last beat of a text
	`IPATP_ASSERT_NEXT(a_state_clear, adv && last_s1, gc_q == 4'd0 && dot_q == 3'd0 && col_q == 4'd0 && !v4b_q && !v6b_q && !gs_q)

endmodule

// ===== tb/tb_ip_address_text_parser_top.sv =====
// Self-checking bench for ip_address_text_parser_top: address texts go in as one
// character per beat; each result beat is checked against typed values for
// known cases, else a local parse model. Depends on ipatp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_ip_address_text_parser_top;
	import ipatp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic        ok;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        v4;
	} addr_result_t;

	localparam addr_result_t NO_ADDR = '{1'b0, 64'd0, 64'd0, 1'b0};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'd0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [USER_W-1:0]   m_tuser;

	ip_address_text_parser_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// parse model state
	logic [15:0] grp [8];
	logic [3:0]  n_grp;
	logic        has_gap;
	logic [3:0]  gap_at;
	logic [15:0] hex_acc;
	logic [2:0]  n_dig;
	logic [7:0]  oct [4];
	logic [2:0]  n_dot;
	logic [3:0]  n_colon;
	logic        after_colon;
	logic        v4_bad;
	logic        v6_bad;
	logic [8:0]  dec_acc;
	logic        lead_colon;
	logic        gap_just;

	addr_result_t expected_addrs [$];
	logic [7:0]   text_buf [$];
	string        case_txt [$];
	bit           case_known [$];
	addr_result_t case_res [$];

	int err_cnt = 0;
	int cycle_cnt = 0;
	int sent_bytes = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;

	function automatic void clear_parse();
		for (int k = 0; k < 8; k++) grp[k] = '0;
		for (int k = 0; k < 4; k++) oct[k] = '0;
		n_grp = '0; has_gap = 1'b0; gap_at = '0; hex_acc = '0; n_dig = '0;
		n_dot = '0; n_colon = '0; after_colon = 1'b0; v4_bad = 1'b0; v6_bad = 1'b0;
		dec_acc = '0; lead_colon = 1'b0; gap_just = 1'b0;
	endfunction

	function automatic void close_group();
		if (n_grp >= V6_GROUPS) begin
			v6_bad = 1'b1;
		end else begin
			grp[n_grp[2:0]] = hex_acc;
			n_grp = n_grp + 4'd1;
		end
		hex_acc = '0;
		n_dig = '0;
	endfunction

	function automatic void take_digit(input logic [3:0] nib, input bit is_dec);
		int d;
		if (is_dec) begin
			d = int'(dec_acc) * 10 + int'(nib);
			dec_acc = (d > int'(DEC_SAT)) ? DEC_SAT : d[8:0];
		end else begin
			v4_bad = 1'b1;
		end
		if (lead_colon) v6_bad = 1'b1;
		if (n_dig >= MAX_DIGITS) begin
			v6_bad = 1'b1;
		end else begin
			hex_acc = {hex_acc[11:0], nib};
			n_dig = n_dig + 3'd1;
		end
		after_colon = 1'b0;
		gap_just = 1'b0;
	endfunction

	function automatic void take_dot();
		v6_bad = 1'b1;
		if (n_dot >= V4_DOTS || dec_acc > OCTET_MAX) v4_bad = 1'b1;
		else oct[n_dot[1:0]] = dec_acc[7:0];
		if (n_dot < DOT_SAT) n_dot = n_dot + 3'd1;
		dec_acc = '0;
		after_colon = 1'b0;
		gap_just = 1'b0;
	endfunction

	function automatic void take_colon();
		v4_bad = 1'b1;
		if (n_colon < COLON_SAT) n_colon = n_colon + 4'd1;
		if (after_colon) begin
			if (gap_just || has_gap) begin
				v6_bad = 1'b1;
			end else begin
				has_gap = 1'b1;
				gap_at = n_grp;
				gap_just = 1'b1;
			end
			lead_colon = 1'b0;
		end else begin
			if (n_dig > 0) close_group();
			else lead_colon = 1'b1;
			gap_just = 1'b0;
		end
		after_colon = 1'b1;
	endfunction

	function automatic addr_result_t close_text();
		addr_result_t r;
		logic [15:0] full [8];
		int n, g;
		r = NO_ADDR;
		if (!v4_bad && n_dot == V4_DOTS && dec_acc <= OCTET_MAX) begin
			oct[3] = dec_acc[7:0];
			r.ok = 1'b1;
			r.v4 = 1'b1;
			r.lo = {16'h0000, V4_MAP_TAG, oct[0], oct[1], oct[2], oct[3]};
		end else begin
			if (lead_colon || (after_colon && !gap_just)) v6_bad = 1'b1;
			if (n_dig > 0) close_group();
			if (n_colon == 0) v6_bad = 1'b1;
			if (has_gap ? (n_grp > V6_GROUPS - 1) : (n_grp != V6_GROUPS)) v6_bad = 1'b1;
			if (!v6_bad) begin
				for (int k = 0; k < 8; k++) full[k] = '0;
				n = n_grp;
				g = has_gap ? int'(gap_at) : n;
				if (g > n) g = n;
				for (int k = 0; k < g && k < 8; k++) full[k] = grp[k];
				for (int k = g; k < n && k < 8; k++) full[(8 - (n - k)) & 7] = grp[k];
				r.ok = 1'b1;
				r.hi = {full[0], full[1], full[2], full[3]};
				r.lo = {full[4], full[5], full[6], full[7]};
			end
		end
		return r;
	endfunction

	function automatic bit parse_char(input logic [7:0] ch, input logic fin,
			output addr_result_t r);
		logic [7:0] t;
		r = NO_ADDR;
		if (ch >= CH_DIG_LO && ch <= CH_DIG_HI) begin
			t = ch - CH_DIG_LO;
			take_digit(t[3:0], 1'b1);
		end else if (ch >= CH_UC_LO && ch <= CH_UC_HI) begin
			t = ch - CH_UC_LO + 8'd10;
			take_digit(t[3:0], 1'b0);
		end else if (ch >= CH_LC_LO && ch <= CH_LC_HI) begin
			t = ch - CH_LC_LO + 8'd10;
			take_digit(t[3:0], 1'b0);
		end else if (ch == CH_DOT) begin
			take_dot();
		end else if (ch == CH_COLON) begin
			take_colon();
		end else begin
			v4_bad = 1'b1;
			v6_bad = 1'b1;
		end
		if (!fin) return 1'b0;
		r = close_text();
		clear_parse();
		return 1'b1;
	endfunction

	task automatic flag_error(input string msg);
		if (err_cnt < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
		err_cnt++;
	endtask

	task automatic check_result(input addr_result_t got);
		addr_result_t want;
		if (expected_addrs.size() == 0) begin
			flag_error("result beat with no text pending");
			return;
		end
		want = expected_addrs.pop_front();
		if (got.ok !== want.ok)
			flag_error($sformatf("addr_valid got %0b want %0b", got.ok, want.ok));
		if (got.hi !== want.hi)
			flag_error($sformatf("addr_high got %h want %h", got.hi, want.hi));
		if (got.lo !== want.lo)
			flag_error($sformatf("addr_low got %h want %h", got.lo, want.lo));
		if (got.v4 !== want.v4)
			flag_error($sformatf("was_ipv4 got %0b want %0b", got.v4, want.v4));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result('{m_tuser[0], m_tdata[63:0], m_tdata[127:64], m_tuser[1]});
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver side: random stalls plus long hold-offs on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_reqs != hold_done) begin
				hold_done = hold_done + 1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic push_beat(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_text(input bit known, input addr_result_t typed);
		addr_result_t r;
		int i;
		for (i = 0; i < text_buf.size(); i++) begin
			push_beat(text_buf[i], i == text_buf.size() - 1);
			if (parse_char(text_buf[i], i == text_buf.size() - 1, r))
				expected_addrs.push_back(known ? typed : r);
		end
		sent_bytes += text_buf.size();
	endtask

	task automatic add_case(input string t, input bit known, input addr_result_t r);
		case_txt.push_back(t);
		case_known.push_back(known);
		case_res.push_back(r);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return CH_DIG_LO + nib;
		if ($urandom_range(1)) return CH_UC_LO + nib - 4'd10;
		return CH_LC_LO + nib - 4'd10;
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(4))
			0: return 8'($urandom_range(255));
			1: return CH_DOT;
			2: return CH_COLON;
			default: return hex_char(4'($urandom_range(15)));
		endcase
	endfunction

	task automatic put_dec(input int v, input int zeros);
		string s;
		s = $sformatf("%0d", v);
		repeat (zeros) text_buf.push_back(CH_DIG_LO);
		for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
	endtask

	task automatic put_hex_group();
		int nd;
		nd = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
		repeat (nd) text_buf.push_back(hex_char(4'($urandom_range(15))));
	endtask

	task automatic gen_ipv4();
		int i;
		text_buf.delete();
		for (i = 0; i < 4; i++) begin
			if (i > 0) text_buf.push_back(CH_DOT);
			case ($urandom_range(9))
				0: ;
				1: put_dec($urandom_range(999), 0);
				2: put_dec($urandom_range(255), $urandom_range(1, 3));
				default: put_dec($urandom_range(255), 0);
			endcase
		end
		if ($urandom_range(19) == 0) text_buf.push_back(CH_DOT);
	endtask

	task automatic gen_ipv6();
		int total, left, i;
		bit gap;
		text_buf.delete();
		gap = $urandom_range(1);
		if (gap) begin
			total = ($urandom_range(9) == 0) ? 8 : $urandom_range(7);
			left = $urandom_range(total);
		end else begin
			total = ($urandom_range(9) == 0) ? $urandom_range(7, 9) : 8;
			left = total;
		end
		for (i = 0; i < left; i++) begin
			if (i > 0) text_buf.push_back(CH_COLON);
			put_hex_group();
		end
		if (gap) begin
			text_buf.push_back(CH_COLON);
			text_buf.push_back(CH_COLON);
			for (i = left; i < total; i++) begin
				if (i > left) text_buf.push_back(CH_COLON);
				put_hex_group();
			end
		end
	endtask

	task automatic gen_noise();
		int len;
		text_buf.delete();
		len = $urandom_range(1, 6);
		repeat (len) text_buf.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick_char());
	endtask

	task automatic mutate_text();
		int pos;
		pos = $urandom_range(text_buf.size() - 1);
		case ($urandom_range(3))
			0: text_buf[pos] = pick_char();
			1: text_buf.insert(pos, pick_char());
			2: if (text_buf.size() > 1) text_buf.delete(pos);
			default: text_buf.insert(pos, CH_COLON);
		endcase
	endtask

	task automatic run_random(input int goal);
		int pick;
		while (sent_bytes < goal) begin
			pick = $urandom_range(99);
			if (pick < 40) gen_ipv4();
			else if (pick < 80) gen_ipv6();
			else gen_noise();
			if (pick < 80 && $urandom_range(3) == 0) mutate_text();
			send_text(1'b0, NO_ADDR);
		end
	endtask

	initial begin
		int i, k;
		clear_parse();
		add_case("0.0.0.0", 1'b1, '{1'b1, 64'd0, {16'h0000, V4_MAP_TAG, 32'h0}, 1'b1});
		add_case("255.255.255.255", 1'b1,
			'{1'b1, 64'd0, {16'h0000, V4_MAP_TAG, 32'hffffffff}, 1'b1});
		add_case("256.1.1.1", 1'b1, NO_ADDR);
		add_case("1.2.3", 1'b1, NO_ADDR);
		add_case("1.2.3.4.5", 1'b1, NO_ADDR);
		add_case("0001.02.3.004", 1'b0, NO_ADDR);
		add_case("...", 1'b0, NO_ADDR);
		add_case("::", 1'b1, '{1'b1, 64'd0, 64'd0, 1'b0});
		add_case("::1", 1'b0, NO_ADDR);
		add_case("1::", 1'b0, NO_ADDR);
		add_case("FFFF:ffff:0:1:2:3:4:Abcd", 1'b0, NO_ADDR);
		add_case("1:2:3:4:5:6:7::", 1'b0, NO_ADDR);
		add_case("1:2:3:4:5:6:7", 1'b1, NO_ADDR);
		add_case("1:2:3:4:5:6:7:8:9", 1'b1, NO_ADDR);
		add_case(":::", 1'b1, NO_ADDR);
		add_case("1::2::3", 1'b1, NO_ADDR);
		add_case(":1::", 1'b1, NO_ADDR);
		add_case("1:", 1'b1, NO_ADDR);
		add_case("12345::", 1'b1, NO_ADDR);
		add_case("1.2::3", 1'b1, NO_ADDR);
		add_case("10.0.0.0/8", 1'b1, NO_ADDR);
		add_case("fe80::1%0", 1'b1, NO_ADDR);
		add_case("123", 1'b1, NO_ADDR);
		add_case(" ", 1'b1, NO_ADDR);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 6;
		sink_idle_pct = 70;
		for (i = 0; i < case_txt.size(); i++) begin
			text_buf.delete();
			for (k = 0; k < case_txt[i].len(); k++) text_buf.push_back(case_txt[i][k]);
			send_text(case_known[i], case_res[i]);
		end
		text_buf = '{8'h00};
		send_text(1'b1, NO_ADDR);
		text_buf = '{8'hff};
		send_text(1'b1, NO_ADDR);

		run_random(283);
		src_idle_pct = 70;
		sink_idle_pct = 6;
		run_random(566);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_reqs = hold_reqs + 1;
		run_random(850);
		s_tvalid <= 1'b0;

		while (expected_addrs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ipatp_pkg.sv
hw/rtl/ip_address_text_parser_top.sv
tb/tb_ip_address_text_parser_top.sv
